[hw/rtl/gcb_pkg.sv]
// ----------------------------------------------------------------------------
// gcb_pkg
// Shared types, codes and widths for the backtracking graph colouring block.
// ----------------------------------------------------------------------------
package gcb_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int MAX_COLORS_DEF   = 16;

    localparam int CFG_W    = 5;   // width of the count registers
    localparam int NBR_W    = 16;  // width of one adjacency row
    localparam int NBR_IW   = 4;   // bits needed to index one row
    localparam int VTX_W    = 4;   // vertex field width
    localparam int COL_W    = 4;   // colour field width
    localparam int SOL_W    = 32;  // solution number width
    localparam int FUNC_W   = 2;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [CFG_W-1:0] VCOUNT_RST = CFG_W'(16);
    localparam logic [CFG_W-1:0] CCOUNT_RST = CFG_W'(3);

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FETCH   = 2'd2;

    // Register index, taken from address bit 2
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_COLOR_COUNT  = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [FUNC_W-1:0] func;
        logic [VTX_W-1:0]  vertex;
        logic [NBR_W-1:0]  neighbors;
    } cmd_t;

    typedef struct packed {
        logic [VTX_W-1:0] vertex_index;
        logic [COL_W-1:0] color_index;
        logic [SOL_W-1:0] solution_number;
        logic             last;
        logic             exhausted;
    } res_t;

endpackage

[hw/rtl/graph_coloring_backtrack.sv]
// Timing: load and restart requests complete in the idle state; a fetch passes
// the load and latch states per level change, the next state per colour tried,
// the check read and compare states per earlier vertex scanned for a conflict,
// then the emit read and write states per vertex emitted. One request at a time;
// the sequencer and its single compare step set the rate; exhausted waits on res_free.
// Reset: asynchronous, active low; no edges, empty search, counter at one.
// ----------------------------------------------------------------------------
// graph_coloring_backtrack
// Enumerates proper m-colourings of a graph of up to MAX_VERTICES vertices by
// depth-first backtracking, one colouring per fetch request.
// ----------------------------------------------------------------------------
module graph_coloring_backtrack
    import gcb_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_COLORS   = MAX_COLORS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,

    // request channel
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [FUNC_W-1:0] func,
    input  logic [VTX_W-1:0]  vertex,
    input  logic [NBR_W-1:0]  neighbors,

    // result channel
    output logic              res_valid,
    input  logic              res_stall,
    output logic [VTX_W-1:0]  vertex_index,
    output logic [COL_W-1:0]  color_index,
    output logic [SOL_W-1:0]  solution_number,
    output logic              last,
    output logic              exhausted
);

    logic [CFG_W-1:0] vcount_reg;
    logic [CFG_W-1:0] ccount_reg;
    logic [CFG_W-1:0] n_cnt;
    logic [CFG_W-1:0] m_cnt;
    logic             cfg_wr;

    cmd_t             cmd;
    logic             busy;
    logic             res_free;
    logic             res_load;
    res_t             res_core;

    logic             res_valid_reg;
    res_t             res_data_reg;

    // Config: written on the access phase of a write, decoded on address bit 2.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? APB_DW'(vcount_reg)
                                                   : APB_DW'(ccount_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VCOUNT_RST;
            ccount_reg <= CCOUNT_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_COLOR_COUNT)
            begin
                ccount_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                vcount_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    // Clamp the counts to what the stores can hold.
    assign n_cnt = (32'(vcount_reg) > MAX_VERTICES) ? CFG_W'(MAX_VERTICES) : vcount_reg;
    assign m_cnt = (32'(ccount_reg) > MAX_COLORS)   ? CFG_W'(MAX_COLORS)   : ccount_reg;

    // Hold off requests while the sequencer is searching or emitting.
    assign req_stall = busy;
    assign cmd       = {req_valid && !busy, func, vertex, neighbors};

    gcb_core #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_COLORS   (MAX_COLORS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .busy     (busy),
        .n_cnt    (n_cnt),
        .m_cnt    (m_cnt),
        .res_free (res_free),
        .res_load (res_load),
        .res      (res_core)
    );

    // Output register: free when empty or being taken this cycle.
    assign res_free = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_data_reg <= res_core;
        end
    end

    assign res_valid       = res_valid_reg;
    assign vertex_index    = res_data_reg.vertex_index;
    assign color_index     = res_data_reg.color_index;
    assign solution_number = res_data_reg.solution_number;
    assign last            = res_data_reg.last;
    assign exhausted       = res_data_reg.exhausted;

endmodule

[hw/rtl/gcb_core.sv]
// ----------------------------------------------------------------------------
// gcb_core
// Search sequencer: adjacency and colour stack memories, level walk, one
// shared compare step for the conflict scan, and result sequencing.
// ----------------------------------------------------------------------------
module gcb_core
    import gcb_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_COLORS   = MAX_COLORS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output logic             busy,
    input  logic [CFG_W-1:0] n_cnt,
    input  logic [CFG_W-1:0] m_cnt,
    input  logic             res_free,
    output logic             res_load,
    output res_t             res
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_COLORS);
    localparam int LW  = ((VW > CFG_W) ? VW : CFG_W) + 1;
    localparam int CMW = ((CW > CFG_W) ? CW : CFG_W) + 1;
    localparam int XW  = (VW > NBR_IW) ? VW : NBR_IW;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_LOAD    = 4'd1;
    localparam logic [3:0] ST_LATCH   = 4'd2;
    localparam logic [3:0] ST_NEXT    = 4'd3;
    localparam logic [3:0] ST_CHK_RD  = 4'd4;
    localparam logic [3:0] ST_CHK_CMP = 4'd5;
    localparam logic [3:0] ST_EMIT_RD = 4'd6;
    localparam logic [3:0] ST_EMIT_WR = 4'd7;
    localparam logic [3:0] ST_EXH     = 4'd8;

    logic [3:0]              state_reg, state_next;
    logic [VW-1:0]           level_reg, level_next;
    logic [MAX_VERTICES-1:0] colored_reg, colored_next;
    logic                    done_reg, done_next;
    logic [SOL_W-1:0]        sol_reg, sol_next;
    logic [MAX_VERTICES-1:0] adj_vld_reg, adj_vld_next;
    logic [CW-1:0]           cur_color_reg, cur_color_next;
    logic [NBR_W-1:0]        cur_row_reg, cur_row_next;
    logic [VW-1:0]           chk_reg, chk_next;
    logic [VW-1:0]           emit_reg, emit_next;

    logic [NBR_W-1:0] adj_mem [MAX_VERTICES];
    logic [CW-1:0]    stk_mem [MAX_VERTICES];
    logic [NBR_W-1:0] adj_q_reg;
    logic [CW-1:0]    stk_q_reg;

    logic             adj_we;
    logic [VW-1:0]    adj_waddr;
    logic             stk_we;
    logic [CW-1:0]    stk_wdata;
    logic [VW-1:0]    rd_addr;

    // Bit idx of a row; vertices beyond the row width have no edge bit.
    function automatic logic row_bit(input logic [NBR_W-1:0] row, input logic [VW-1:0] idx);
        logic [XW-1:0] ix;
        ix = XW'(idx);
        return (32'(idx) < NBR_W) && row[ix[NBR_IW-1:0]];
    endfunction

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_waddr] <= cmd.neighbors;
        end
        if (stk_we)
        begin
            stk_mem[level_reg] <= stk_wdata;
        end
        adj_q_reg <= adj_vld_reg[rd_addr] ? adj_mem[rd_addr] : '0;
        stk_q_reg <= stk_mem[rd_addr];
    end

    always_comb
    begin
        logic [LW-1:0]  lvl_w;
        logic [LW-1:0]  n_w;
        logic [CMW-1:0] m_w;
        logic           at_top;
        logic           ok_go;
        logic           conflict;

        lvl_w    = LW'(level_reg);
        n_w      = LW'(n_cnt);
        m_w      = CMW'(m_cnt);
        at_top   = (lvl_w + LW'(1)) == n_w;
        ok_go    = 1'b0;
        conflict = 1'b0;

        state_next     = state_reg;
        level_next     = level_reg;
        colored_next   = colored_reg;
        done_next      = done_reg;
        sol_next       = sol_reg;
        adj_vld_next   = adj_vld_reg;
        cur_color_next = cur_color_reg;
        cur_row_next   = cur_row_reg;
        chk_next       = chk_reg;
        emit_next      = emit_reg;

        adj_we    = 1'b0;
        adj_waddr = VW'(cmd.vertex);
        stk_we    = 1'b0;
        stk_wdata = '0;
        rd_addr   = level_reg;
        res_load  = 1'b0;
        res       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    case (cmd.func)
                        FUNC_LOAD:
                        begin
                            if (32'(cmd.vertex) < MAX_VERTICES)
                            begin
                                adj_we                  = 1'b1;
                                adj_vld_next[adj_waddr] = 1'b1;
                            end
                        end
                        FUNC_RESTART:
                        begin
                            colored_next = '0;
                            level_next   = '0;
                            done_next    = 1'b0;
                            sol_next     = SOL_W'(1);
                        end
                        FUNC_FETCH:
                        begin
                            state_next = done_reg ? ST_EXH : ST_LOAD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                cur_color_next = stk_q_reg;
                cur_row_next   = adj_q_reg;
                state_next     = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (lvl_w >= n_w || m_w == '0
                    || (colored_reg[level_reg] && (CMW'(cur_color_reg) + CMW'(1)) >= m_w))
                begin
                    // no colour left here: uncolour and step back
                    colored_next[level_reg] = 1'b0;
                    if (level_reg == '0)
                    begin
                        done_next  = 1'b1;
                        state_next = ST_EXH;
                    end
                    else
                    begin
                        level_next = level_reg - VW'(1);
                        state_next = ST_LOAD;
                    end
                end
                else
                begin
                    stk_we    = 1'b1;
                    stk_wdata = colored_reg[level_reg] ? cur_color_reg + CW'(1) : '0;
                    colored_next[level_reg] = 1'b1;
                    cur_color_next = stk_wdata;
                    if (level_reg == '0)
                    begin
                        ok_go = 1'b1;
                    end
                    else
                    begin
                        chk_next   = '0;
                        state_next = ST_CHK_RD;
                    end
                end
            end
            ST_CHK_RD:
            begin
                rd_addr    = chk_reg;
                state_next = ST_CHK_CMP;
            end
            ST_CHK_CMP:
            begin
                rd_addr  = chk_reg;
                conflict = colored_reg[chk_reg] && (stk_q_reg == cur_color_reg)
                           && (row_bit(adj_q_reg, level_reg) || row_bit(cur_row_reg, chk_reg));
                if (conflict)
                begin
                    state_next = ST_NEXT;
                end
                else if (chk_reg == level_reg - VW'(1))
                begin
                    ok_go = 1'b1;
                end
                else
                begin
                    chk_next   = chk_reg + VW'(1);
                    state_next = ST_CHK_RD;
                end
            end
            ST_EMIT_RD:
            begin
                rd_addr    = emit_reg;
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                rd_addr = emit_reg;
                res.vertex_index    = VTX_W'(emit_reg);
                res.color_index     = COL_W'(stk_q_reg);
                res.solution_number = sol_reg;
                res.last            = (LW'(emit_reg) + LW'(1)) == n_w;
                res.exhausted       = 1'b0;
                if (res_free)
                begin
                    res_load = 1'b1;
                    if (res.last)
                    begin
                        if (sol_reg != '1)
                        begin
                            sol_next = sol_reg + SOL_W'(1);
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_next  = emit_reg + VW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_EXH:
            begin
                res.last      = 1'b1;
                res.exhausted = 1'b1;
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // colour accepted: emit on the last vertex, else climb one level
        if (ok_go)
        begin
            if (at_top)
            begin
                emit_next  = '0;
                state_next = ST_EMIT_RD;
            end
            else
            begin
                level_next = level_reg + VW'(1);
                state_next = ST_LOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            level_reg   <= '0;
            colored_reg <= '0;
            done_reg    <= 1'b0;
            sol_reg     <= SOL_W'(1);
            adj_vld_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            level_reg   <= level_next;
            colored_reg <= colored_next;
            done_reg    <= done_next;
            sol_reg     <= sol_next;
            adj_vld_reg <= adj_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_color_reg <= cur_color_next;
        cur_row_reg   <= cur_row_next;
        chk_reg       <= chk_next;
        emit_reg      <= emit_next;
    end

endmodule

[bench/gcb_bench_pkg.sv]
// ----------------------------------------------------------------------------
// gcb_bench_pkg
// Colouring predictor and result ledger for the graph colouring bench: mirrors
// the backtracking search request by request and checks every result in order.
// ----------------------------------------------------------------------------
package gcb_bench_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import gcb_pkg::*;

    // Function code the block must ignore
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    class colouring_board;

        logic [NBR_W-1:0] rows [MAX_VERTICES_DEF];
        logic [CFG_W-1:0] stack [MAX_VERTICES_DEF];
        bit               placed [MAX_VERTICES_DEF];
        int               depth;
        bit               finished;
        logic [SOL_W-1:0] ordinal;
        logic [CFG_W-1:0] vertices_reg;
        logic [CFG_W-1:0] colours_reg;
        res_t             due [$];
        int unsigned      failures;

        function new();
            foreach (rows[i])
                rows[i] = '0;
            vertices_reg = VCOUNT_RST;
            colours_reg  = CCOUNT_RST;
            failures     = 0;
            clear_search();
        endfunction

        function void clear_search();
            foreach (stack[i])
            begin
                stack[i]  = '0;
                placed[i] = 1'b0;
            end
            depth    = 0;
            finished = 1'b0;
            ordinal  = 1;
        endfunction

        function void note_config(logic idx, logic [CFG_W-1:0] value);
            if (idx == REG_VERTEX_COUNT)
                vertices_reg = value;
            else
                colours_reg = value;
        endfunction

        // Step the colour at the current depth; 0 when none is left
        function bit advance(int n, int m);
            if (depth >= n || m == 0)
                return 1'b0;
            if (placed[depth])
            begin
                if (stack[depth] >= m - 1)
                    return 1'b0;
                stack[depth] = stack[depth] + 1'b1;
            end
            else
            begin
                placed[depth] = 1'b1;
                stack[depth]  = '0;
            end
            return 1'b1;
        endfunction

        function void fetch_next();
            int   n;
            int   m;
            bit   have;
            bit   clash;
            res_t item;
            n = (vertices_reg > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(vertices_reg);
            m = (colours_reg > MAX_COLORS_DEF) ? MAX_COLORS_DEF : int'(colours_reg);
            while (!finished)
            begin
                do
                begin
                    have  = advance(n, m);
                    clash = 1'b0;
                    if (have)
                        for (int i = 0; i < depth; i++)
                            if (placed[i] && stack[i] == stack[depth]
                                && (rows[i][depth] || rows[depth][i]))
                                clash = 1'b1;
                end
                while (have && clash);

                if (have && depth == n - 1)
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        item.vertex_index    = VTX_W'(i);
                        item.color_index     = stack[i][COL_W-1:0];
                        item.solution_number = ordinal;
                        item.last            = (i == n - 1);
                        item.exhausted       = 1'b0;
                        due.push_back(item);
                    end
                    if (ordinal != '1)
                        ordinal++;
                    return;
                end

                if (have)
                    depth++;
                else
                begin
                    if (depth < MAX_VERTICES_DEF)
                        placed[depth] = 1'b0;
                    if (depth == 0)
                        finished = 1'b1;
                    else
                        depth--;
                end
            end
            item           = '0;
            item.last      = 1'b1;
            item.exhausted = 1'b1;
            due.push_back(item);
        endfunction

        function void note_request(logic [FUNC_W-1:0] f, logic [VTX_W-1:0] v,
                                   logic [NBR_W-1:0] nb);
            case (f)
                FUNC_LOAD:    rows[v] = nb;
                FUNC_RESTART: clear_search();
                FUNC_FETCH:   fetch_next();
                default:      ;
            endcase
        endfunction

        function int unsigned waiting();
            return due.size();
        endfunction

        function void compare_field(string name, logic [SOL_W-1:0] want,
                                    logic [SOL_W-1:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (due.size() == 0)
            begin
                $display("%0t: unexpected result, vertex %0d colour %0d solution %0d",
                         $time, got.vertex_index, got.color_index, got.solution_number);
                failures++;
                return;
            end
            want = due.pop_front();
            compare_field("vertex_index", want.vertex_index, got.vertex_index);
            compare_field("color_index", want.color_index, got.color_index);
            compare_field("solution_number", want.solution_number, got.solution_number);
            compare_field("last", want.last, got.last);
            compare_field("exhausted", want.exhausted, got.exhausted);
        endfunction

        function int unsigned close_out();
            if (due.size() != 0)
            begin
                $display("%0t: %0d expected results never arrived", $time, due.size());
                failures += due.size();
            end
            return failures;
        endfunction

    endclass

endpackage

[bench/tb_graph_coloring_backtrack.sv]
// ----------------------------------------------------------------------------
// tb_graph_coloring_backtrack
// Self-checking bench for the backtracking graph colouring block: a directed
// opening over the corner cases, then random graph episodes (small random
// graphs, long paths, cliques, noise) under three idling regimes.
// ----------------------------------------------------------------------------
module tb_graph_coloring_backtrack;

    timeunit 1ns;
    timeprecision 1ps;

    import gcb_pkg::*;
    import gcb_bench_pkg::*;

    // Random requests to issue after the directed opening
    localparam int unsigned RANDOM_ITEMS   = 370;
    // Load and restart complete in the idle state; leave a margin before touching registers
    localparam int unsigned SETTLE_CYCLES  = 8;
    // Longest fetch here (six vertices, four colours, full search) must finish
    // well within this limit
    localparam int unsigned WATCHDOG_LIMIT = 400000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [APB_AW-1:0] paddr     = '0;
    logic [APB_DW-1:0] pwdata    = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              req_valid = 1'b0;
    logic              req_stall;
    logic [FUNC_W-1:0] func      = FUNC_LOAD;
    logic [VTX_W-1:0]  vertex    = '0;
    logic [NBR_W-1:0]  neighbors = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    logic [VTX_W-1:0]  vertex_index;
    logic [COL_W-1:0]  color_index;
    logic [SOL_W-1:0]  solution_number;
    logic              last;
    logic              exhausted;

    colouring_board board;
    int unsigned    send_idle_pct = 36;
    int unsigned    stall_pct     = 63;
    int unsigned    issued        = 0;
    int unsigned    quiet_cycles  = 0;

    graph_coloring_backtrack dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .func            (func),
        .vertex          (vertex),
        .neighbors       (neighbors),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .vertex_index    (vertex_index),
        .color_index     (color_index),
        .solution_number (solution_number),
        .last            (last),
        .exhausted       (exhausted)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: stall at random at the rate of the current regime
    always @(posedge clk)
        res_stall <= ($urandom_range(99, 0) < stall_pct);

    // Check every result taken at this edge against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            board.check_result({vertex_index, color_index, solution_number, last, exhausted});
    end

    // Watchdog: count cycles with no request, result or register traffic
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("graph_coloring_backtrack regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one request, idling first at random, and hold it until taken.
    // The prediction is made here, at the accepting edge, so the ledger is
    // always up to date by the time the caller looks at it.
    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [VTX_W-1:0] v,
                                input logic [NBR_W-1:0] nb);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        func      <= f;
        vertex    <= v;
        neighbors <= nb;
        do
            @(posedge clk);
        while (req_stall);
        board.note_request(f, v, nb);
        if (f != FUNC_UNUSED)
            issued++;
    endtask

    // Restart, fetch and the ignored code carry don't-care payload: randomise it
    task automatic send_command(input logic [FUNC_W-1:0] f);
        send_request(f, VTX_W'($urandom), NBR_W'($urandom));
    endtask

    // Drop valid and wait until every expected result is in, then let the
    // block finish any trailing load or restart
    task automatic settle();
        req_valid <= 1'b0;
        while (board.waiting() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands when pready is seen
    task automatic write_register(input logic idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.note_config(idx, value);
    endtask

    initial
    begin
        int unsigned      kind;
        int unsigned      phase;
        int               n;
        int               m;
        int               reg_n;
        logic [NBR_W-1:0] row;
        logic [NBR_W-1:0] dir;
        int unsigned      failures;

        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed opening -------------------------------------------
        // Reset settings: sixteen vertices, three colours, no edges
        send_command(FUNC_FETCH);
        // The unused code must be swallowed without a result
        send_command(FUNC_UNUSED);
        // Join vertex fifteen to everything (own bit set too) mid-search,
        // then resume without a restart
        send_request(FUNC_LOAD, VTX_W'(15), 16'hFFFF);
        send_command(FUNC_FETCH);
        send_request(FUNC_LOAD, VTX_W'(15), 16'h0000);
        settle();

        // No colours: exhausted straight away, and again on a second fetch
        write_register(REG_VERTEX_COUNT, CFG_W'(3));
        write_register(REG_COLOR_COUNT, CFG_W'(0));
        send_command(FUNC_RESTART);
        send_command(FUNC_FETCH);
        send_command(FUNC_FETCH);
        settle();

        // No vertices
        write_register(REG_VERTEX_COUNT, CFG_W'(0));
        write_register(REG_COLOR_COUNT, CFG_W'(2));
        send_command(FUNC_RESTART);
        send_command(FUNC_FETCH);
        settle();

        // Edge held in one row only; the other row has just its own bit
        write_register(REG_VERTEX_COUNT, CFG_W'(2));
        send_request(FUNC_LOAD, VTX_W'(0), 16'h0002);
        send_request(FUNC_LOAD, VTX_W'(1), 16'h0002);
        send_command(FUNC_RESTART);
        repeat (3) send_command(FUNC_FETCH);
        settle();

        // Vertex count above its maximum saturates; one colour, no edges
        write_register(REG_VERTEX_COUNT, CFG_W'(31));
        write_register(REG_COLOR_COUNT, CFG_W'(1));
        send_request(FUNC_LOAD, VTX_W'(0), 16'h0000);
        send_command(FUNC_RESTART);
        repeat (2) send_command(FUNC_FETCH);

        // ---- random episodes --------------------------------------------
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            // First third: sender idles lightly, receiver heavily; then the
            // other way round; then flat out
            phase = issued * 3 / RANDOM_ITEMS;
            case (phase)
                0:
                begin
                    send_idle_pct = 36;
                    stall_pct     = 63;
                end
                1:
                begin
                    send_idle_pct = 63;
                    stall_pct     = 36;
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase

            // Registers only change with the block idle
            settle();
            kind = $urandom_range(9, 0);
            if (kind <= 5)
            begin
                // Small random graph; keep the search tree bounded
                n = $urandom_range(6, 0);
                m = $urandom_range(4, 0);
                if (n <= 3 && $urandom_range(5, 0) == 0)
                    m = $urandom_range(31, 16);
                write_register(REG_VERTEX_COUNT, CFG_W'(n));
                write_register(REG_COLOR_COUNT, CFG_W'(m));
                for (int v = 0; v < n; v++)
                    if ($urandom_range(3, 0) != 0)
                        send_request(FUNC_LOAD, VTX_W'(v), NBR_W'($urandom));
                repeat ($urandom_range(2, 0))
                    send_request(FUNC_LOAD, VTX_W'($urandom_range(15, 0)), NBR_W'($urandom));
                // Now and then carry on the old search under the new graph
                if ($urandom_range(3, 0) != 0)
                    send_command(FUNC_RESTART);
                repeat ($urandom_range(8, 1))
                    send_command(FUNC_FETCH);
            end
            else if (kind <= 7)
            begin
                // Long path: every prefix extends, so each colouring is cheap.
                // Each edge sits in one row only, picked at random.
                case ($urandom_range(2, 0))
                    0:       reg_n = 16;
                    1:       reg_n = 31;
                    default: reg_n = $urandom_range(15, 7);
                endcase
                m = $urandom_range(3, 2);
                write_register(REG_VERTEX_COUNT, CFG_W'(reg_n));
                write_register(REG_COLOR_COUNT, CFG_W'(m));
                dir = NBR_W'($urandom);
                for (int v = 0; v < MAX_VERTICES_DEF; v++)
                begin
                    row = '0;
                    if (v < MAX_VERTICES_DEF - 1 && !dir[v])
                        row[v + 1] = 1'b1;
                    if (v > 0 && dir[v - 1])
                        row[v - 1] = 1'b1;
                    if ($urandom_range(3, 0) == 0)
                        row[v] = 1'b1;
                    send_request(FUNC_LOAD, VTX_W'(v), row);
                end
                send_command(FUNC_RESTART);
                repeat ($urandom_range(4, 1))
                    send_command(FUNC_FETCH);
            end
            else if (kind == 8)
            begin
                // Clique with as many colours as vertices: reaches the top
                // colour and the top vertex
                n     = $urandom_range(16, 4);
                reg_n = (n == 16 && $urandom_range(1, 0) == 1) ? 31 : n;
                m     = (n == 16 && $urandom_range(1, 0) == 1) ? 31 : n;
                write_register(REG_VERTEX_COUNT, CFG_W'(reg_n));
                write_register(REG_COLOR_COUNT, CFG_W'(m));
                for (int v = 0; v < n; v++)
                    send_request(FUNC_LOAD, VTX_W'(v), 16'hFFFF);
                send_command(FUNC_RESTART);
                repeat ($urandom_range(3, 1))
                    send_command(FUNC_FETCH);
            end
            else
            begin
                // Noise: any code in any order on a tiny graph
                write_register(REG_VERTEX_COUNT, CFG_W'($urandom_range(5, 1)));
                write_register(REG_COLOR_COUNT, CFG_W'($urandom_range(3, 0)));
                repeat ($urandom_range(12, 6))
                    send_request(FUNC_W'($urandom_range(FUNC_UNUSED, FUNC_LOAD)),
                                 VTX_W'($urandom), NBR_W'($urandom));
            end
        end

        settle();
        failures = board.close_out();
        if (failures == 0)
            $display("graph_coloring_backtrack regression: pass");
        else
            $display("graph_coloring_backtrack regression: fail");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/gcb_pkg.sv
hw/rtl/gcb_core.sv
hw/rtl/graph_coloring_backtrack.sv
bench/gcb_bench_pkg.sv
bench/tb_graph_coloring_backtrack.sv
